FILE: src/ffi_pkg.sv
// ----------------------------------------------------------------------------
// ffi_pkg
// Shared types and constants for the FIFO with fourth-place insert.
// ----------------------------------------------------------------------------
package ffi_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // width of the data_out result field
    localparam int OUT_DATA_W = 32;

    // place from the head that an insert lands in, counted from zero
    localparam int FOURTH_OFFSET = 3;

    typedef enum logic [1:0] {
        MODE_PUSH        = 2'd0,
        MODE_PUSH_FOURTH = 2'd1,
        MODE_POP         = 2'd2,
        MODE_CLEAR       = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic    now_empty;
        status_t status;
    } res_info_t;

endpackage

FILE: src/ffi_ram.sv
// ----------------------------------------------------------------------------
// ffi_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ffi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: src/ffi_ctrl.sv
// ----------------------------------------------------------------------------
// ffi_ctrl
// Queue sequencer: head/tail/count bookkeeping and the entry-shift walk
// through the RAM for fourth-place inserts.
// ----------------------------------------------------------------------------
module ffi_ctrl #(
    parameter int DEPTH      = ffi_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = ffi_pkg::DATA_WIDTH_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // operation input
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [1:0]               in_mode,
    input  logic [DATA_WIDTH-1:0]    in_data,
    // result output
    output logic                     res_valid,
    input  logic                     res_ready,
    output ffi_pkg::res_info_t       res_info,
    output logic [DATA_WIDTH-1:0]    res_data,
    // RAM port
    output logic                     ram_wr_en,
    output logic [$clog2(DEPTH)-1:0] ram_wr_addr,
    output logic [DATA_WIDTH-1:0]    ram_wr_data,
    output logic                     ram_rd_en,
    output logic [$clog2(DEPTH)-1:0] ram_rd_addr,
    input  logic [DATA_WIDTH-1:0]    ram_rd_data
);
    import ffi_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(DEPTH - 1);
    localparam logic [ADDR_W-1:0] FOURTH   = ADDR_W'(FOURTH_OFFSET);
    localparam logic [ADDR_W:0]   DEPTH_V  = (ADDR_W + 1)'(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SHIFT,
        S_POP_WAIT,
        S_RESP
    } state_t;

    state_t                state_reg, state_next;
    logic [ADDR_W-1:0]     head_reg, head_next;
    logic [ADDR_W-1:0]     tail_reg, tail_next;
    logic [ADDR_W-1:0]     count_reg, count_next;
    logic [ADDR_W-1:0]     k_reg, k_next;
    logic                  wr_pend_reg, wr_pend_next;
    logic [ADDR_W-1:0]     wr_addr_reg, wr_addr_next;
    logic [DATA_WIDTH-1:0] word_reg, word_next;
    status_t               status_reg, status_next;
    logic [DATA_WIDTH-1:0] data_reg, data_next;

    function automatic logic [ADDR_W-1:0] inc_idx(input logic [ADDR_W-1:0] i);
        return (i == LAST_IDX) ? '0 : i + ADDR_W'(1);
    endfunction

    // head plus offset, modulo DEPTH; both terms are below DEPTH
    function automatic logic [ADDR_W-1:0] add_idx(input logic [ADDR_W-1:0] base,
                                                  input logic [ADDR_W-1:0] offs);
        logic [ADDR_W:0] sum;
        sum = {1'b0, base} + {1'b0, offs};
        if (sum >= DEPTH_V) begin
            sum = sum - DEPTH_V;
        end
        return sum[ADDR_W-1:0];
    endfunction

    always_comb begin
        state_next   = state_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        k_next       = k_reg;
        wr_pend_next = wr_pend_reg;
        wr_addr_next = wr_addr_reg;
        word_next    = word_reg;
        status_next  = status_reg;
        data_next    = data_reg;
        in_ready     = 1'b0;
        res_valid    = 1'b0;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = tail_reg;
        ram_wr_data  = in_data;
        ram_rd_en    = 1'b0;
        ram_rd_addr  = head_reg;

        unique case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    word_next   = in_data;
                    data_next   = '0;
                    status_next = ST_OK;
                    state_next  = S_RESP;
                    unique case (mode_t'(in_mode))
                        MODE_PUSH, MODE_PUSH_FOURTH: begin
                            if (count_reg == LAST_IDX) begin
                                status_next = ST_FULL;
                            end else if (mode_t'(in_mode) == MODE_PUSH ||
                                         count_reg <= FOURTH) begin
                                ram_wr_en  = 1'b1;
                                tail_next  = inc_idx(tail_reg);
                                count_next = count_reg + ADDR_W'(1);
                            end else begin
                                // walk the entries from the tail back to the fourth place
                                k_next       = count_reg;
                                wr_pend_next = 1'b0;
                                tail_next    = inc_idx(tail_reg);
                                count_next   = count_reg + ADDR_W'(1);
                                state_next   = S_SHIFT;
                            end
                        end
                        MODE_POP: begin
                            if (count_reg == '0) begin
                                status_next = ST_EMPTY;
                            end else begin
                                ram_rd_en  = 1'b1;
                                head_next  = inc_idx(head_reg);
                                count_next = count_reg - ADDR_W'(1);
                                state_next = S_POP_WAIT;
                            end
                        end
                        MODE_CLEAR: begin
                            head_next  = '0;
                            tail_next  = '0;
                            count_next = '0;
                        end
                        default: begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end

            S_SHIFT: begin
                // read entry k-1 while writing the word read last cycle into its new place
                if (k_reg > FOURTH) begin
                    ram_rd_en    = 1'b1;
                    ram_rd_addr  = add_idx(head_reg, k_reg - ADDR_W'(1));
                    wr_pend_next = 1'b1;
                    wr_addr_next = add_idx(head_reg, k_reg);
                    k_next       = k_reg - ADDR_W'(1);
                end else begin
                    wr_pend_next = 1'b0;
                end
                if (wr_pend_reg) begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = wr_addr_reg;
                    ram_wr_data = ram_rd_data;
                end else if (k_reg <= FOURTH) begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = add_idx(head_reg, FOURTH);
                    ram_wr_data = word_reg;
                    state_next  = S_RESP;
                end
            end

            S_POP_WAIT: begin
                data_next  = ram_rd_data;
                state_next = S_RESP;
            end

            S_RESP: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res_info.now_empty = (count_reg == '0);
    assign res_info.status    = status_reg;
    assign res_data           = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            k_reg       <= '0;
            wr_pend_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            k_reg       <= k_next;
            wr_pend_reg <= wr_pend_next;
        end
        wr_addr_reg <= wr_addr_next;
        word_reg    <= word_next;
        status_reg  <= status_next;
        data_reg    <= data_next;
    end

    // never hold more than DEPTH-1 words
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= LAST_IDX)
        else $error("item count exceeds capacity");

    // the shift walk never reads the entry it writes in the same cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_wr_en && ram_rd_en) |-> (ram_wr_addr != ram_rd_addr))
        else $error("RAM read and write collide");

    // a clear leaves an empty queue behind
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready && mode_t'(in_mode) == MODE_CLEAR)
            |=> (count_reg == '0 && head_reg == '0 && tail_reg == '0))
        else $error("clear did not empty the queue");

    // a pop on an empty queue reports empty and leaves the count alone
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready && mode_t'(in_mode) == MODE_POP && count_reg == '0)
            |=> (status_reg == ST_EMPTY && count_reg == '0))
        else $error("empty pop not refused");

endmodule

FILE: src/fifo_with_fourth_place_insert_unit.sv
// ----------------------------------------------------------------------------
// fifo_with_fourth_place_insert_unit
// Word FIFO with tail push, fourth-place insert, head pop and clear.
// ----------------------------------------------------------------------------
// One operation is taken at a time and each returns one result. A tail push,
// a clear or a refused operation goes from idle straight to the result state,
// a pop waits first for its one RAM read. A fourth-place insert into a queue
// holding n words walks entries n-1 down to 3 back by one place through the
// single RAM port pair, one entry per cycle, and then writes the new word to
// the fourth place. A new operation is taken once the previous result sits in
// the output register, which holds it while m_tready is low. The queue holds
// at most DEPTH-1 words; the RAM needs no clearing after reset.
module fifo_with_fourth_place_insert_unit #(
    parameter int DEPTH      = ffi_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = ffi_pkg::DATA_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((DATA_WIDTH + 7) / 8)*8-1:0] s_tdata,   // data_in
    input  logic [1:0]                          s_tuser,   // mode
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [ffi_pkg::OUT_DATA_W-1:0]      m_tdata,   // data_out
    output logic [2:0]                          m_tuser    // status[1:0], now_empty
);
    import ffi_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH);

    logic                  res_valid;
    logic                  res_ready;
    res_info_t             res_info;
    logic [DATA_WIDTH-1:0] res_data;
    logic [OUT_DATA_W-1:0] res_data_out;

    logic                  ram_wr_en;
    logic [ADDR_W-1:0]     ram_wr_addr;
    logic [DATA_WIDTH-1:0] ram_wr_data;
    logic                  ram_rd_en;
    logic [ADDR_W-1:0]     ram_rd_addr;
    logic [DATA_WIDTH-1:0] ram_rd_data;

    logic                  m_valid_reg;
    res_info_t             m_info_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;

    ffi_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    ffi_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_mode     (s_tuser),
        .in_data     (s_tdata[DATA_WIDTH-1:0]),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_info    (res_info),
        .res_data    (res_data),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    // fit the stored word to the result field
    generate
        if (DATA_WIDTH >= OUT_DATA_W) begin : g_trunc
            assign res_data_out = res_data[OUT_DATA_W-1:0];
        end else begin : g_ext
            assign res_data_out = {{(OUT_DATA_W - DATA_WIDTH){1'b0}}, res_data};
        end
    endgenerate

    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (res_valid && res_ready) begin
            m_info_reg <= res_info;
            m_data_reg <= res_data_out;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = {m_info_reg.now_empty, m_info_reg.status};

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for fifo_with_fourth_place_insert_unit.
// A shadow queue predicts the status, the popped word and the empty flag of
// every accepted operation. Results are checked in order as they leave the
// block. Directed tests cover the queue edges, and random traffic follows
// under changing back-pressure.
// ----------------------------------------------------------------------------
module tb;
    import ffi_pkg::*;

    localparam int DEPTH       = 16;
    localparam int DW          = 32;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        status_t        status;
        logic [DW-1:0]  word;
        logic           now_empty;
    } op_result_t;

    logic           aclk;
    logic           aresetn;
    logic           s_tvalid;
    logic           s_tready;
    logic [DW-1:0]  s_tdata;    // data_in
    logic [1:0]     s_tuser;    // mode
    logic           m_tvalid;
    logic           m_tready;
    logic [DW-1:0]  m_tdata;    // data_out
    logic [2:0]     m_tuser;    // status[1:0], now_empty

    logic [DW-1:0]  queue_words[$];
    op_result_t     pending_results[$];
    int             mismatch_count = 0;
    int             cycle_count    = 0;
    int             send_idle_pct  = 0;
    int             recv_idle_pct  = 0;

    fifo_with_fourth_place_insert_unit #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DW)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Apply one operation to the shadow queue and return its result.
    function automatic op_result_t apply_op(mode_t op, logic [DW-1:0] word);
        op_result_t res;
        res.status = ST_OK;
        res.word   = '0;
        case (op)
            MODE_PUSH, MODE_PUSH_FOURTH: begin
                if (queue_words.size() + 1 >= DEPTH)
                    res.status = ST_FULL;
                else if (op == MODE_PUSH || queue_words.size() <= FOURTH_OFFSET)
                    queue_words.push_back(word);
                else
                    queue_words.insert(FOURTH_OFFSET, word);
            end
            MODE_POP: begin
                if (queue_words.size() == 0)
                    res.status = ST_EMPTY;
                else
                    res.word = queue_words.pop_front();
            end
            default: queue_words.delete();
        endcase
        res.now_empty = (queue_words.size() == 0);
        return res;
    endfunction

    // Called and returns at a falling edge.
    task automatic send_op(mode_t op, logic [DW-1:0] word);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= word;
        forever begin
            @(posedge aclk);
            if (s_tready) break;
        end
        pending_results.push_back(apply_op(op, word));
        @(negedge aclk);
    endtask

    // Hold off the sender until every outstanding result has come back.
    task automatic drain_results();
        while (pending_results.size() != 0) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
    endtask

    always @(posedge aclk) begin : check_results
        op_result_t exp_res;
        res_info_t  info;
        if (aresetn && m_tvalid && m_tready) begin
            info = res_info_t'(m_tuser);
            if (pending_results.size() == 0) begin
                $error("result transfer with no expectation waiting");
                mismatch_count++;
            end else begin
                exp_res = pending_results.pop_front();
                if (info.status !== exp_res.status) begin
                    $error("status: expected %0d, got %0d", exp_res.status, info.status);
                    mismatch_count++;
                end
                if (m_tdata !== exp_res.word) begin
                    $error("data_out: expected %h, got %h", exp_res.word, m_tdata);
                    mismatch_count++;
                end
                if (info.now_empty !== exp_res.now_empty) begin
                    $error("now_empty: expected %0d, got %0d",
                           exp_res.now_empty, info.now_empty);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic test_empty_queue();
        send_op(MODE_POP, 32'hFFFF_FFFF);
        send_op(MODE_PUSH, 32'h0000_0000);
        send_op(MODE_PUSH, 32'hFFFF_FFFF);
        // three words or fewer held: acts as a tail push
        send_op(MODE_PUSH_FOURTH, 32'hA5A5_5A5A);
        send_op(MODE_PUSH_FOURTH, 32'h0000_0003);
    endtask

    task automatic test_fourth_insert();
        send_op(MODE_PUSH_FOURTH, 32'h1234_5678);
        send_op(MODE_POP, 32'h0);
        send_op(MODE_POP, 32'h0);
    endtask

    task automatic test_full_queue();
        int i;
        // fill to DEPTH-1, inserts at the back end shift the most entries
        for (i = 0; queue_words.size() < DEPTH - 1; i++)
            send_op((i % 2) ? MODE_PUSH_FOURTH : MODE_PUSH, 32'h8000_0000 >> i);
        send_op(MODE_PUSH, 32'hDEAD_BEEF);
        send_op(MODE_PUSH_FOURTH, 32'hCAFE_F00D);
    endtask

    task automatic test_clear();
        send_op(MODE_CLEAR, 32'h5555_5555);
        send_op(MODE_POP, 32'h0);
        send_op(MODE_CLEAR, 32'h0);
    endtask

    task automatic test_random(int n_ops);
        int             i;
        int             push_pct;
        mode_t          op;
        logic [DW-1:0]  word;
        push_pct = 50;
        for (i = 0; i < n_ops; i++) begin
            // drift the fill level between empty and full
            if (i % 20 == 0) begin
                case ($urandom_range(2))
                    0:       push_pct = 25;
                    1:       push_pct = 50;
                    default: push_pct = 85;
                endcase
            end
            if ($urandom_range(99) < 2)
                op = MODE_CLEAR;
            else if ($urandom_range(99) < push_pct)
                op = $urandom_range(1) ? MODE_PUSH_FOURTH : MODE_PUSH;
            else
                op = MODE_POP;
            case ($urandom_range(7))
                0:       word = '0;
                1:       word = '1;
                2:       word = 32'h1 << $urandom_range(31);
                3:       word = ~(32'h1 << $urandom_range(31));
                default: word = $urandom;
            endcase
            send_op(op, word);
        end
    endtask

    task automatic finish_run();
        drain_results();
        s_tvalid <= 1'b0;
        repeat (40) @(posedge aclk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = MODE_PUSH;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_empty_queue();
        test_fourth_insert();
        test_full_queue();
        test_clear();

        send_idle_pct = 23;
        recv_idle_pct = 85;
        test_random(140);
        drain_results();

        send_idle_pct = 85;
        recv_idle_pct = 23;
        test_random(130);
        drain_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(130);

        finish_run();
    end

endmodule

FILE: sim.f
src/ffi_pkg.sv
src/ffi_ram.sv
src/ffi_ctrl.sv
src/fifo_with_fourth_place_insert_unit.sv
dv/tb.sv
